[sv/pvas_pkg.sv]
package pvas_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int TBL_LEN       = 24;
  localparam int NSTG          = (CORDIC_STAGES < TBL_LEN) ? CORDIC_STAGES : TBL_LEN;
  localparam int RW            = 33;
  localparam int VW            = 35;
  localparam int PIPE_DEPTH    = 2 * NSTG + 5;
  localparam logic [31:0] GAIN_INV = 32'h9B74EDA8;
  localparam logic [31:0] HALF_TURN = 32'h80000000;

  typedef struct packed {
    logic        op;
    logic [15:0] angle_a;
    logic [15:0] mag_a;
    logic [15:0] angle_b;
    logic [15:0] mag_b;
  } req_t;

  typedef struct packed {
    logic [15:0] angle_out;
    logic [16:0] mag_out;
    logic        zero_result;
  } rsp_t;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [31:0]   z;
    logic [1:0]           q;
  } rot_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic [31:0]          z;
  } vec_t;

  function automatic logic [31:0] atan_lut(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
      15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
      21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] to_phase(input logic [15:0] ang);
    logic [63:0] w;
    w = 64'(ang) << (32 - ANGLE_BITS);
    return w[31:0];
  endfunction

endpackage

[sv/pvas_rot_stage.sv]
module pvas_rot_stage
  import pvas_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [4:0]  shift,
  input  logic [31:0] atan,
  input  rot_t        d,
  output rot_t        q
);

  rot_t nxt;

  always_comb begin
    nxt = d;
    if (d.z >= 0) begin
      nxt.x = d.x - (d.y >>> shift);
      nxt.y = d.y + (d.x >>> shift);
      nxt.z = d.z - $signed(atan);
    end else begin
      nxt.x = d.x + (d.y >>> shift);
      nxt.y = d.y - (d.x >>> shift);
      nxt.z = d.z + $signed(atan);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

[sv/pvas_vec_stage.sv]
module pvas_vec_stage
  import pvas_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [4:0]  shift,
  input  logic [31:0] atan,
  input  vec_t        d,
  output vec_t        q
);

  vec_t nxt;

  always_comb begin
    if (d.y >= 0) begin
      nxt.x = d.x + (d.y >>> shift);
      nxt.y = d.y - (d.x >>> shift);
      nxt.z = d.z + atan;
    end else begin
      nxt.x = d.x - (d.y >>> shift);
      nxt.y = d.y + (d.x >>> shift);
      nxt.z = d.z - atan;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

[sv/polar_vector_add_subtract.sv]
// channel  valid      stall      payload  dir
// req      req_valid  req_stall  req      in   (op, angle_a, mag_a, angle_b, mag_b)
// rsp      rsp_valid  rsp_stall  rsp      out  (angle_out, mag_out, zero_result)
// One transfer per cycle unless rsp stalls. Pipeline: start register, rotation
// and vectoring CORDIC chains (one stage per register), fold, gain and output.
// rst clears all valid bits; payload registers are not reset.
// A stalled result freezes the whole pipeline and raises req_stall.
module polar_vector_add_subtract
  import pvas_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic                  en;
  logic [PIPE_DEPTH-1:0] v;
  rot_t                  ra [0:NSTG];
  rot_t                  rb [0:NSTG];
  vec_t                  vv [0:NSTG];
  logic [48:0]           pl;
  logic [48:0]           ph;
  logic [31:0]           zm;
  logic [33:0]           magp;
  logic [31:0]           za;
  rsp_t                  rsp_next;

  assign en        = !(v[PIPE_DEPTH-1] && rsp_stall);
  assign req_stall = !en;
  assign rsp_valid = v[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[PIPE_DEPTH-2:0], req_valid};
    end
  end

  // polar start values
  logic [31:0] pa, pb;
  logic [47:0] xa0, xb0;
  always_comb begin
    pa  = to_phase(req.angle_a);
    pb  = to_phase(req.angle_b) + (req.op ? HALF_TURN : 32'h0);
    xa0 = 48'(req.mag_a) * 48'(GAIN_INV);
    xb0 = 48'(req.mag_b) * 48'(GAIN_INV);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra[0].x <= RW'($signed({1'b0, xa0[47:18]}));
      ra[0].y <= '0;
      ra[0].z <= $signed({2'b00, pa[29:0]});
      ra[0].q <= pa[31:30];
      rb[0].x <= RW'($signed({1'b0, xb0[47:18]}));
      rb[0].y <= '0;
      rb[0].z <= $signed({2'b00, pb[29:0]});
      rb[0].q <= pb[31:30];
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_rot
    pvas_rot_stage u_a (
      .clk(clk), .en(en), .shift(5'(i)), .atan(atan_lut(i)), .d(ra[i]), .q(ra[i+1])
    );
    pvas_rot_stage u_b (
      .clk(clk), .en(en), .shift(5'(i)), .atan(atan_lut(i)), .d(rb[i]), .q(rb[i+1])
    );
  end

  // quadrant fold, sum, half-plane fold
  logic signed [VW-1:0] qxa, qya, qxb, qyb, sx, sy;
  always_comb begin
    case (ra[NSTG].q)
      2'd1:    begin qxa = -VW'(ra[NSTG].y); qya =  VW'(ra[NSTG].x); end
      2'd2:    begin qxa = -VW'(ra[NSTG].x); qya = -VW'(ra[NSTG].y); end
      2'd3:    begin qxa =  VW'(ra[NSTG].y); qya = -VW'(ra[NSTG].x); end
      default: begin qxa =  VW'(ra[NSTG].x); qya =  VW'(ra[NSTG].y); end
    endcase
    case (rb[NSTG].q)
      2'd1:    begin qxb = -VW'(rb[NSTG].y); qyb =  VW'(rb[NSTG].x); end
      2'd2:    begin qxb = -VW'(rb[NSTG].x); qyb = -VW'(rb[NSTG].y); end
      2'd3:    begin qxb =  VW'(rb[NSTG].y); qyb = -VW'(rb[NSTG].x); end
      default: begin qxb =  VW'(rb[NSTG].x); qyb =  VW'(rb[NSTG].y); end
    endcase
    sx = qxa + qxb;
    sy = qya + qyb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sx < 0) begin
        vv[0].x <= -sx;
        vv[0].y <= -sy;
        vv[0].z <= HALF_TURN;
      end else begin
        vv[0].x <= sx;
        vv[0].y <= sy;
        vv[0].z <= '0;
      end
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_vec
    pvas_vec_stage u_v (
      .clk(clk), .en(en), .shift(5'(i)), .atan(atan_lut(i)), .d(vv[i]), .q(vv[i+1])
    );
  end

  // gain correction, split into two partial products
  logic [33:0] xc;
  assign xc = (vv[NSTG].x < 0) ? '0 : vv[NSTG].x[33:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pl <= 49'(xc[16:0]) * 49'(GAIN_INV);
      ph <= 49'(xc[33:17]) * 49'(GAIN_INV);
      zm <= vv[NSTG].z;
    end
  end

  logic [66:0] psum;
  assign psum = 67'(pl) + (67'(ph) << 17);

  always_ff @(posedge clk) begin
    if (en) begin
      magp <= psum[65:32];
      za   <= zm;
    end
  end

  logic [34:0] mr;
  logic [20:0] mq;
  logic [32:0] zr;
  logic [ANGLE_BITS-1:0] ang;
  always_comb begin
    mr = 35'(magp) + 35'd8192;
    mq = mr[34:14];
    zr = 33'(za) + (33'd1 << (31 - ANGLE_BITS));
    ang = zr[31:32-ANGLE_BITS];
    if (mq == '0) begin
      rsp_next.angle_out   = '0;
      rsp_next.mag_out     = '0;
      rsp_next.zero_result = 1'b1;
    end else begin
      rsp_next.angle_out   = 16'(ang);
      rsp_next.mag_out     = (mq > 21'd131071) ? 17'h1FFFF : mq[16:0];
      rsp_next.zero_result = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import pvas_pkg::*;

  localparam int N_STG = (CORDIC_STAGES < TBL_LEN) ? CORDIC_STAGES : TBL_LEN;
  localparam int LAT = 2 * N_STG + 5;
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  rsp_t resultant_q[$];
  int errors;
  int sent;
  int got;
  int zeros;
  int stall_mode;

  polar_vector_add_subtract DUT (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] atan_val(int i);
    logic [31:0] t[24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  function automatic logic [31:0] phase_of(logic [15:0] ang);
    logic [63:0] m;
    m = 64'(ang) & ((64'd1 << ANGLE_BITS) - 1);
    return 32'(m << (32 - ANGLE_BITS));
  endfunction

  function automatic void rotate(input logic [31:0] ph, input logic [15:0] mag,
                                 output longint ox, output longint oy);
    longint x, y, z, nx;
    logic [63:0] p;
    p = 64'(mag) * 64'(GAIN_INV);
    x = longint'(p >> 18);
    y = 0;
    z = longint'({2'b00, ph[29:0]});
    for (int i = 0; i < N_STG; i++) begin
      if (z >= 0) begin
        nx = x - sra(y, i); y = y + sra(x, i); z -= longint'(atan_val(i));
      end else begin
        nx = x + sra(y, i); y = y - sra(x, i); z += longint'(atan_val(i));
      end
      x = nx;
    end
    case (ph[31:30])
      2'd1: begin ox = -y; oy = x; end
      2'd2: begin ox = -x; oy = -y; end
      2'd3: begin ox = y; oy = -x; end
      default: begin ox = x; oy = y; end
    endcase
  endfunction

  function automatic rsp_t resultant(req_t r);
    logic [31:0] pa, pb, z;
    longint xa, ya, xb, yb, x, y, nx;
    logic [63:0] m, a;
    rsp_t o;
    pa = phase_of(r.angle_a);
    pb = phase_of(r.angle_b);
    if (r.op == OP_SUB) pb += HALF_TURN;
    rotate(pa, r.mag_a, xa, ya);
    rotate(pb, r.mag_b, xb, yb);
    x = xa + xb;
    y = ya + yb;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF_TURN;
    end
    for (int i = 0; i < N_STG; i++) begin
      if (y >= 0) begin
        nx = x + sra(y, i); y = y - sra(x, i); z += atan_val(i);
      end else begin
        nx = x - sra(y, i); y = y + sra(x, i); z -= atan_val(i);
      end
      x = nx;
    end
    if (x < 0) x = 0;
    m = (64'(x) * 64'(GAIN_INV)) >> 32;
    m = (m + 64'd8192) >> 14;
    if (m > 64'd131071) m = 64'd131071;
    a = (64'(z) + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
    a &= (64'd1 << ANGLE_BITS) - 1;
    if (m == 0) begin
      o.angle_out = '0; o.mag_out = '0; o.zero_result = 1'b1;
    end else begin
      o.angle_out = a[15:0]; o.mag_out = m[16:0]; o.zero_result = 1'b0;
    end
    return o;
  endfunction

  task automatic report(string what, logic [31:0] g, logic [31:0] e);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, g, e, got);
  endtask

  // checker: compare every result transfer against the oldest prediction
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (resultant_q.size() == 0) begin
        report("unexpected result", 32'(rsp), 32'd0);
      end else begin
        e = resultant_q.pop_front();
        if (rsp.angle_out !== e.angle_out)
          report("angle_out", 32'(rsp.angle_out), 32'(e.angle_out));
        if (rsp.mag_out !== e.mag_out)
          report("mag_out", 32'(rsp.mag_out), 32'(e.mag_out));
        if (rsp.zero_result !== e.zero_result)
          report("zero_result", 32'(rsp.zero_result), 32'(e.zero_result));
        if (e.zero_result) zeros++;
      end
      got++;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(3) == 0);
      2: rsp_stall <= ($urandom_range(1) == 0);
      default: rsp_stall <= ($urandom_range(9) != 0);
    endcase
    if ($urandom_range(63) == 0) stall_mode <= $urandom_range(3);
  end

  int burst_left;

  task automatic send(req_t r);
    int gap;
    logic stalled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(0, 6);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= r;
    // req_stall is settled by the falling edge and holds through the next rising edge
    do begin
      @(negedge clk);
      stalled = req_stall;
      @(posedge clk);
    end while (stalled);
    resultant_q.push_back(resultant(r));
    sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    while (resultant_q.size() != 0) @(posedge clk);
  endtask

  function automatic req_t mk(logic op, logic [15:0] aa, logic [15:0] ma,
                              logic [15:0] ab, logic [15:0] mb);
    req_t r;
    r.op = op; r.angle_a = aa; r.mag_a = ma; r.angle_b = ab; r.mag_b = mb;
    return r;
  endfunction

  task automatic test_extremes();
    send(mk(OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send(mk(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send(mk(OP_SUB, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
    send(mk(OP_ADD, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
    send(mk(OP_SUB, 16'h4000, 16'hFFFF, 16'hC000, 16'hFFFF));
    send(mk(OP_ADD, 16'h4000, 16'h1234, 16'h4000, 16'h0001));
    send(mk(OP_ADD, 16'hC000, 16'h8000, 16'h0000, 16'h0000));
    send(mk(OP_ADD, 16'h8000, 16'h0001, 16'h0000, 16'h0000));
    send(mk(OP_ADD, 16'h2000, 16'h0001, 16'h0000, 16'h0000));
  endtask

  task automatic test_cancel();
    logic [15:0] a, m;
    // opposite phases and equal angles under subtraction
    for (int i = 0; i < 8; i++) begin
      a = 16'($urandom); m = 16'($urandom);
      send(mk(OP_ADD, a, m, a + 16'h8000, m));
      send(mk(OP_SUB, a, m, a, m));
    end
    send(mk(OP_SUB, 16'h1234, 16'h0001, 16'h1234, 16'h0002));
  endtask

  task automatic test_random(int n);
    req_t r;
    int k;
    for (int i = 0; i < n; i++) begin
      r = req_t'(65'({$urandom, $urandom, $urandom}));
      k = $urandom_range(9);
      if (k == 0) r.mag_a = 16'($urandom_range(3));
      if (k == 1) r.mag_b = 16'($urandom_range(3));
      if (k == 2) begin
        r.angle_b = r.op ? r.angle_a : r.angle_a + 16'h8000;
        r.mag_b = 16'(r.mag_a + $urandom_range(2) - 1);
      end
      if (k == 3) r.angle_a = {2'($urandom_range(3)), 14'h0};
      send(r);
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    stall_mode = 0;
    errors = 0; sent = 0; got = 0; zeros = 0; burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_cancel();
    drain();
    test_random(1100);
    drain();
    repeat (LAT + 10) @(posedge clk);
    $display("tb: %0d vector pairs sent, %0d results checked, %0d zero resultants",
             sent, got, zeros);
    if (errors == 0 && resultant_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
